// ----- rtl/core/lpu_pkg.sv -----
// ---------------------------------------------------------------------------
// lpu_pkg: shared types, constants and a helper function
// Payload structs, register indexes and a saturating fixed-point helper.
// ---------------------------------------------------------------------------
package lpu_pkg;

  localparam int Iterations = 5;
  localparam int QFrac      = 28;
  localparam int QW         = 32;
  localparam int DivW       = 64;   // dividend width of a normalise/refine divide
  localparam int DivSteps   = 4;    // quotient bits resolved per pipeline stage
  localparam int DivStages  = DivW / DivSteps;
  localparam int SideW      = 32 + 32 + 1 + 16 + 16;  // payload riding beside a divide

  typedef enum logic [2:0] {
    REG_FOCAL_X = 3'd0, REG_FOCAL_Y = 3'd1, REG_CENTER_X = 3'd2, REG_CENTER_Y = 3'd3,
    REG_K1 = 3'd4, REG_K2 = 3'd5, REG_P1 = 3'd6, REG_P2 = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
  } in_item_t;

  typedef struct packed {
    logic signed [19:0] corrected_x;
    logic signed [19:0] corrected_y;
    logic               out_of_range;
  } out_item_t;

  typedef struct packed {
    logic [15:0]        focal_x;
    logic [15:0]        focal_y;
    logic [15:0]        center_x;
    logic [15:0]        center_y;
    logic signed [31:0] k1;
    logic signed [31:0] k2;
    logic signed [31:0] p1;
    logic signed [31:0] p2;
  } cfg_t;

  // Saturate a 66-bit signed value to Q4.28; flag on clip.
  function automatic logic [32:0] qsat(input logic signed [65:0] v);
    logic [32:0] r;
    if (v > 66'sd2147483647) r = {1'b1, 32'h7fffffff};
    else if (v < -66'sd2147483648) r = {1'b1, 32'h80000000};
    else r = {1'b0, v[31:0]};
    return r;
  endfunction

endpackage

// ----- rtl/core/lpu_div.sv -----
// ---------------------------------------------------------------------------
// lpu_div: pipelined signed divider
// Restoring division, four quotient bits per stage, truncation toward zero.
// The quotient is saturated to Q4.28; side data rides along unchanged.
// ---------------------------------------------------------------------------
module lpu_div import lpu_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [DivW-1:0]  in_num,
  input  logic signed [DivW-1:0]  in_den,
  input  logic [SideW-1:0]        in_side,
  output logic                    out_valid,
  output logic [QW-1:0]           out_q,
  output logic                    out_sat,
  output logic [SideW-1:0]        out_side
);

  logic [DivW-1:0]  rem_r  [DivStages+1];
  logic [DivW-1:0]  quo_r  [DivStages+1];
  logic [DivW-1:0]  dvs_r  [DivStages+1];
  logic             neg_r  [DivStages+1];
  logic [SideW-1:0] side_r [DivStages+1];
  logic             vld_r  [DivStages+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= DivStages; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i <= DivStages; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= '0;
      quo_r[0]  <= in_num[DivW-1] ? DivW'(-in_num) : in_num;
      dvs_r[0]  <= in_den[DivW-1] ? DivW'(-in_den) : in_den;
      neg_r[0]  <= in_num[DivW-1] ^ in_den[DivW-1];
      side_r[0] <= in_side;
    end
  end

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    logic [DivW-1:0] rem_nxt, quo_nxt;
    always_comb begin
      logic [DivW:0] trial;
      logic          msb;
      rem_nxt = rem_r[s];
      quo_nxt = quo_r[s];
      for (int b = 0; b < DivSteps; b++) begin
        msb     = quo_nxt[DivW-1];
        trial   = {rem_nxt, msb} - {1'b0, dvs_r[s]};
        quo_nxt = {quo_nxt[DivW-2:0], ~trial[DivW]};
        rem_nxt = trial[DivW] ? {rem_nxt[DivW-2:0], msb} : trial[DivW-1:0];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1]  <= rem_nxt;
        quo_r[s+1]  <= quo_nxt;
        dvs_r[s+1]  <= dvs_r[s];
        neg_r[s+1]  <= neg_r[s];
        side_r[s+1] <= side_r[s];
      end
    end
  end

  // Clamp the magnitude just past the Q4.28 range so both signs still clip.
  logic [DivW:0] mag;
  logic signed [65:0] sq;
  logic [32:0] sat;
  always_comb begin
    mag = {1'b0, quo_r[DivStages]};
    if (mag > 65'd2147483649) mag = 65'd2147483649;
    sq  = neg_r[DivStages] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    sat = qsat(sq);
  end

  assign out_valid = vld_r[DivStages];
  assign out_q     = sat[31:0];
  assign out_sat   = sat[32];
  assign out_side  = side_r[DivStages];

endmodule

// ----- rtl/core/lens_point_undistort.sv -----
// ---------------------------------------------------------------------------
// lens_point_undistort: fixed-point iterative lens undistortion
// Normalises a distorted pixel, inverts radial/tangential distortion over
// five refinement rounds and maps the point back to pixels.
// ---------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall carry one pixel pair; a transfer happens when valid is
//   high and stall is low. out_valid/out_stall return one corrected pair
//   with an out_of_range flag for every input transfer, in order.
//   cfg_we/cfg_index/cfg_data write the eight registers; write only while
//   the pipeline is empty.
// Throughput: one transfer per clock. The whole datapath is a single
//   pipeline with one global advance enable. An output register holds the
//   finished result; while it is full and out_stall is high every stage
//   freezes, so in_stall follows out_stall combinationally in that case.
// Pipeline: 125 register stages - 17 for the normalise divide, 21 per round
//   (four multiply/add stages plus a 17-stage divide), two for the pixel
//   mapping and the output register.
// Reset: synchronous, active low; clears valid bits and loads the default
//   register values (focal length 16384 px, all other registers zero).
// ---------------------------------------------------------------------------
module lens_point_undistort import lpu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t cfg_r;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{focal_x: 16'd16384, focal_y: 16'd16384, default: '0};
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_FOCAL_X:  cfg_r.focal_x  <= cfg_data[15:0];
        REG_FOCAL_Y:  cfg_r.focal_y  <= cfg_data[15:0];
        REG_CENTER_X: cfg_r.center_x <= cfg_data[15:0];
        REG_CENTER_Y: cfg_r.center_y <= cfg_data[15:0];
        REG_K1:       cfg_r.k1       <= cfg_data;
        REG_K2:       cfg_r.k2       <= cfg_data;
        REG_P1:       cfg_r.p1       <= cfg_data;
        default:      cfg_r.p2       <= cfg_data;
      endcase
    end
  end

  // Output register. Advance the pipeline whenever the register is empty or
  // its result leaves this cycle.
  out_item_t  res_r;
  logic       out_vld_r;
  logic       en;
  logic       pipe_vld;
  out_item_t  pipe_res;

  assign en        = !out_vld_r || !out_stall;
  assign out_valid = out_vld_r;
  assign out_data  = res_r;
  assign in_stall  = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= pipe_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (en) res_r <= pipe_res;
  end

  // Normalisation divide for x and y.
  logic signed [DivW-1:0] nx_num, ny_num;
  assign nx_num = DivW'($signed({1'b0, in_data.pixel_x}) - $signed({1'b0, cfg_r.center_x}))
                  <<< QFrac;
  assign ny_num = DivW'($signed({1'b0, in_data.pixel_y}) - $signed({1'b0, cfg_r.center_y}))
                  <<< QFrac;

  logic        nv_x, nv_y, ns_x, ns_y;
  logic [31:0] nq_x, nq_y;
  logic [SideW-1:0] nside_x, nside_y;
  logic        fzx, fzy;

  lpu_div u_nx (
    .clk, .rst_n, .en, .in_valid(in_valid && en),
    .in_num(nx_num), .in_den(DivW'({1'b0, cfg_r.focal_x})),
    .in_side({32'(nx_num >>> QFrac), 32'd0, 1'b0, cfg_r.focal_x, 16'd0}),
    .out_valid(nv_x), .out_q(nq_x), .out_sat(ns_x), .out_side(nside_x)
  );
  lpu_div u_ny (
    .clk, .rst_n, .en, .in_valid(in_valid && en),
    .in_num(ny_num), .in_den(DivW'({1'b0, cfg_r.focal_y})),
    .in_side({32'(ny_num >>> QFrac), 32'd0, 1'b0, cfg_r.focal_y, 16'd0}),
    .out_valid(nv_y), .out_q(nq_y), .out_sat(ns_y), .out_side(nside_y)
  );

  // Zero focal length: sign of the difference; drop the divider's flag then.
  logic signed [31:0] dxn, dyn, x0, y0;
  logic fl0;
  always_comb begin
    dxn = $signed(nside_x[SideW-1 -: 32]);
    dyn = $signed(nside_y[SideW-1 -: 32]);
    fzx = nside_x[31:16] == 16'd0;
    fzy = nside_y[31:16] == 16'd0;
    fl0 = (fzx ? (dxn != 0) : ns_x) | (fzy ? (dyn != 0) : ns_y);
    x0  = nq_x;
    y0  = nq_y;
    if (fzx) begin
      x0 = (dxn == 0) ? 32'sd0 : (dxn > 0 ? 32'h7fffffff : 32'h80000000);
    end
    if (fzy) begin
      y0 = (dyn == 0) ? 32'sd0 : (dyn > 0 ? 32'h7fffffff : 32'h80000000);
    end
  end

  // Refinement rounds.
  typedef struct packed {
    logic        vld;
    logic [31:0] x0, y0, x, y;
    logic        flag;
  } rnd_t;

  rnd_t rin [Iterations+1];
  assign rin[0] = '{vld: nv_x, x0: x0, y0: y0, x: x0, y: y0, flag: fl0};

  for (genvar r = 0; r < Iterations; r++) begin : g_round
    // stage A: squares and cross product
    rnd_t a_r, b_r, c_r, d_r;
    logic signed [63:0] xx_r, yy_r, xy_r;
    logic signed [31:0] r2_r, xyq_r, sx_r;
    logic signed [63:0] k2r_r, p1xy_r, p2sx_r, p1sy_r, p2xy_r;
    logic signed [31:0] dx_r, dy_r;
    logic signed [63:0] tr_r;
    logic signed [31:0] den_r;
    logic               fa, fb, fc, fd;
    logic [32:0] s_r2, s_xy, s_sx, s_sy, s_t, s_dx, s_dy, s_den, s_nx, s_ny;
    logic signed [63:0] xxf, yyf;

    always_comb begin
      xxf  = xx_r >>> QFrac;
      yyf  = yy_r >>> QFrac;
      s_r2 = qsat(66'(xxf) + 66'(yyf));
      s_xy = qsat(66'(xy_r >>> QFrac));
      s_sx = qsat(66'($signed(s_r2[31:0])) + 66'(xxf <<< 1));
      s_sy = qsat(66'($signed(s_r2[31:0])) + 66'(yyf <<< 1));
      fa   = s_r2[32] | s_xy[32] | s_sx[32] | s_sy[32];
      s_t  = qsat(66'(k2r_r >>> QFrac) + 66'(cfg_r.k1));
      s_dx = qsat(66'(p1xy_r >>> (QFrac - 1)) + 66'(p2sx_r >>> QFrac));
      s_dy = qsat(66'(p1sy_r >>> QFrac) + 66'(p2xy_r >>> (QFrac - 1)));
      fb   = s_t[32] | s_dx[32] | s_dy[32];
      s_den = qsat(66'(tr_r >>> QFrac) + 66'sd268435456);
      fc   = s_den[32];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        a_r.vld <= 1'b0; b_r.vld <= 1'b0; c_r.vld <= 1'b0; d_r.vld <= 1'b0;
      end else if (en) begin
        a_r.vld <= rin[r].vld; b_r.vld <= a_r.vld;
        c_r.vld <= b_r.vld;    d_r.vld <= c_r.vld;
      end
      if (en) begin
        {a_r.x0, a_r.y0, a_r.x, a_r.y, a_r.flag} <=
          {rin[r].x0, rin[r].y0, rin[r].x, rin[r].y, rin[r].flag};
        xx_r <= $signed(rin[r].x) * $signed(rin[r].x);
        yy_r <= $signed(rin[r].y) * $signed(rin[r].y);
        xy_r <= $signed(rin[r].x) * $signed(rin[r].y);
        // stage B: coefficient products
        {b_r.x0, b_r.y0, b_r.x, b_r.y} <= {a_r.x0, a_r.y0, a_r.x, a_r.y};
        b_r.flag <= a_r.flag | fa;
        r2_r   <= s_r2[31:0];
        k2r_r  <= cfg_r.k2 * $signed(s_r2[31:0]);
        p1xy_r <= cfg_r.p1 * $signed(s_xy[31:0]);
        p2xy_r <= cfg_r.p2 * $signed(s_xy[31:0]);
        p2sx_r <= cfg_r.p2 * $signed(s_sx[31:0]);
        p1sy_r <= cfg_r.p1 * $signed(s_sy[31:0]);
        // stage C: t * r2 and the tangential offsets dx, dy
        {c_r.x0, c_r.y0, c_r.x, c_r.y} <= {b_r.x0, b_r.y0, b_r.x, b_r.y};
        c_r.flag <= b_r.flag | fb;
        tr_r  <= $signed(s_t[31:0]) * r2_r;
        dx_r  <= s_dx[31:0];
        dy_r  <= s_dy[31:0];
        // stage D: denominator; dx and dy carried along
        {d_r.x0, d_r.y0, d_r.x, d_r.y} <= {c_r.x0, c_r.y0, c_r.x, c_r.y};
        d_r.flag <= c_r.flag | fc;
        den_r <= s_den[31:0];
        xyq_r <= dx_r;
        sx_r  <= dy_r;
      end
    end

    // stage E: divide (den <= 0 leaves x, y unchanged)
    logic bad;
    logic dvx, dvy, dsx, dsy;
    logic [31:0] qx, qy;
    logic [SideW-1:0] sdx, sdy;
    logic signed [31:0] nxv, nyv;
    always_comb begin
      bad = den_r <= 0;
      s_nx = qsat(66'($signed(d_r.x0)) - 66'(xyq_r));
      s_ny = qsat(66'($signed(d_r.y0)) - 66'(sx_r));
      nxv  = s_nx[31:0];
      nyv  = s_ny[31:0];
      fd   = !bad && (s_nx[32] | s_ny[32]);
    end

    lpu_div u_dx (
      .clk, .rst_n, .en, .in_valid(d_r.vld),
      .in_num(DivW'(nxv) <<< QFrac),
      .in_den(bad ? DivW'(1) : DivW'(den_r)),
      .in_side({d_r.x0, d_r.x, d_r.flag | fd | bad, bad, 31'd0}),
      .out_valid(dvx), .out_q(qx), .out_sat(dsx), .out_side(sdx)
    );
    lpu_div u_dy (
      .clk, .rst_n, .en, .in_valid(d_r.vld),
      .in_num(DivW'(nyv) <<< QFrac),
      .in_den(bad ? DivW'(1) : DivW'(den_r)),
      .in_side({d_r.y0, d_r.y, 1'b0, 32'd0}),
      .out_valid(dvy), .out_q(qy), .out_sat(dsy), .out_side(sdy)
    );

    logic keep;
    assign keep = sdx[31];
    assign rin[r+1] = '{
      vld:  dvx & dvy,
      x0:   sdx[SideW-1 -: 32],
      y0:   sdy[SideW-1 -: 32],
      x:    keep ? sdx[SideW-33 -: 32] : qx,
      y:    keep ? sdy[SideW-33 -: 32] : qy,
      flag: sdx[32] | (!keep & (dsx | dsy))
    };
  end

  // Back to pixels: multiply, then shift, add and clamp.
  logic        o1_vld_r, o2_vld_r;
  logic signed [63:0] px_r, py_r;
  logic        o1_flag_r;
  out_item_t   o2_r;
  logic signed [65:0] cxs, cys;
  always_comb begin
    cxs = 66'(px_r >>> QFrac) + 66'({1'b0, cfg_r.center_x});
    cys = 66'(py_r >>> QFrac) + 66'({1'b0, cfg_r.center_y});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o1_vld_r <= 1'b0;
      o2_vld_r <= 1'b0;
    end else if (en) begin
      o1_vld_r <= rin[Iterations].vld;
      o2_vld_r <= o1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r      <= $signed(rin[Iterations].x) * $signed({1'b0, cfg_r.focal_x});
      py_r      <= $signed(rin[Iterations].y) * $signed({1'b0, cfg_r.focal_y});
      o1_flag_r <= rin[Iterations].flag;
      o2_r.corrected_x <= (cxs > 66'sd524287) ? 20'sd524287 :
                          (cxs < -66'sd524288) ? -20'sd524288 : cxs[19:0];
      o2_r.corrected_y <= (cys > 66'sd524287) ? 20'sd524287 :
                          (cys < -66'sd524288) ? -20'sd524288 : cys[19:0];
      o2_r.out_of_range <= o1_flag_r | cxs > 66'sd524287 | cxs < -66'sd524288
                           | cys > 66'sd524287 | cys < -66'sd524288;
    end
  end

  assign pipe_vld = o2_vld_r;
  assign pipe_res = o2_r;

endmodule

// ----- tb/lpu_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lpu_checker: scoreboard for the lens undistortion pipeline
// Tracks register writes, predicts the corrected point for every input
// transfer and compares each output transfer against the oldest prediction.
// ---------------------------------------------------------------------------
module lpu_checker import lpu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          mismatches,
  output int          pending
);

  localparam longint One  = 64'sd268435456;
  localparam longint QHi  = 64'sd2147483647;
  localparam longint QLo  = -64'sd2147483648;
  localparam longint PxHi = 64'sd524287;
  localparam longint PxLo = -64'sd524288;

  cfg_t      lens;
  out_item_t corrected_q[$];

  function automatic longint clip(longint v, longint lo, longint hi, inout bit flag);
    if (v > hi) begin
      flag = 1'b1;
      return hi;
    end
    if (v < lo) begin
      flag = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic longint to_norm(longint pix, longint c, longint f, inout bit flag);
    longint d;
    d = pix - c;
    if (f == 0) begin
      if (d == 0) return 0;
      flag = 1'b1;
      return (d > 0) ? QHi : QLo;
    end
    return clip((d * One) / f, QLo, QHi, flag);
  endfunction

  function automatic out_item_t undistort(in_item_t pt, cfg_t c);
    bit     flag;
    longint x0, y0, x, y, xx, yy, r2, xy, t, den, sx, sy, dx, dy, nx, ny, k1, k2, p1, p2;
    out_item_t r;
    flag = 1'b0;
    k1 = c.k1;
    k2 = c.k2;
    p1 = c.p1;
    p2 = c.p2;
    x0 = to_norm(longint'(pt.pixel_x), longint'(c.center_x), longint'(c.focal_x), flag);
    y0 = to_norm(longint'(pt.pixel_y), longint'(c.center_y), longint'(c.focal_y), flag);
    x = x0;
    y = y0;
    for (int i = 0; i < Iterations; i++) begin
      // arithmetic right shift of a signed product rounds toward minus infinity
      xx  = (x * x) >>> 28;
      yy  = (y * y) >>> 28;
      r2  = clip(xx + yy, QLo, QHi, flag);
      xy  = clip((x * y) >>> 28, QLo, QHi, flag);
      t   = clip(((k2 * r2) >>> 28) + k1, QLo, QHi, flag);
      den = clip(((t * r2) >>> 28) + One, QLo, QHi, flag);
      sx  = clip(r2 + 2 * xx, QLo, QHi, flag);
      sy  = clip(r2 + 2 * yy, QLo, QHi, flag);
      dx  = clip(((p1 * xy) >>> 27) + ((p2 * sx) >>> 28), QLo, QHi, flag);
      dy  = clip(((p1 * sy) >>> 28) + ((p2 * xy) >>> 27), QLo, QHi, flag);
      if (den <= 0) begin
        // hold the point for this round
        flag = 1'b1;
      end else begin
        nx = clip(x0 - dx, QLo, QHi, flag);
        ny = clip(y0 - dy, QLo, QHi, flag);
        x  = clip((nx * One) / den, QLo, QHi, flag);
        y  = clip((ny * One) / den, QLo, QHi, flag);
      end
    end
    r.corrected_x = 20'(clip(((x * longint'(c.focal_x)) >>> 28) + longint'(c.center_x),
                             PxLo, PxHi, flag));
    r.corrected_y = 20'(clip(((y * longint'(c.focal_y)) >>> 28) + longint'(c.center_y),
                             PxLo, PxHi, flag));
    r.out_of_range = flag;
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      lens <= '{focal_x: 16'd16384, focal_y: 16'd16384, default: '0};
      corrected_q.delete();
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_FOCAL_X:  lens.focal_x  <= cfg_data[15:0];
          REG_FOCAL_Y:  lens.focal_y  <= cfg_data[15:0];
          REG_CENTER_X: lens.center_x <= cfg_data[15:0];
          REG_CENTER_Y: lens.center_y <= cfg_data[15:0];
          REG_K1:       lens.k1       <= cfg_data;
          REG_K2:       lens.k2       <= cfg_data;
          REG_P1:       lens.p1       <= cfg_data;
          REG_P2:       lens.p2       <= cfg_data;
        endcase
      end
      if (in_valid && !in_stall) corrected_q.push_back(undistort(in_data, lens));
      if (out_valid && !out_stall) begin
        if (corrected_q.size() == 0) begin
          $error("unexpected output transfer: %p", out_data);
          mismatches++;
        end else begin
          want = corrected_q.pop_front();
          if (out_data.corrected_x !== want.corrected_x) begin
            $error("corrected_x: expected %0d, got %0d", want.corrected_x,
                   out_data.corrected_x);
            mismatches++;
          end
          if (out_data.corrected_y !== want.corrected_y) begin
            $error("corrected_y: expected %0d, got %0d", want.corrected_y,
                   out_data.corrected_y);
            mismatches++;
          end
          if (out_data.out_of_range !== want.out_of_range) begin
            $error("out_of_range: expected %0b, got %0b", want.out_of_range,
                   out_data.out_of_range);
            mismatches++;
          end
        end
      end
    end
    pending = corrected_q.size();
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: top level for the lens undistortion pipeline
// Drives pixel pairs and register settings, throttles both channels and
// reports the verdict from the scoreboard's mismatch count.
// ---------------------------------------------------------------------------
module testbench import lpu_pkg::*; ();

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  int          mismatches;
  int          pending;
  int          send_idle_pct;
  int          stall_pct;

  lens_point_undistort dut (.*);

  lpu_checker u_checker (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Receiver throttle: redraw the stall every cycle.
  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // Offer one point and hold it until the transfer happens.
  task automatic send_point(input logic [15:0] px, input logic [15:0] py);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{pixel_x: px, pixel_y: py};
    do @(posedge clk); while (in_stall);
  endtask

  // Drain the pipeline: only write registers once nothing is in flight.
  task automatic drain();
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      #1;
    end while (pending != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic load_lens(input logic [15:0] fx, input logic [15:0] fy,
                           input logic [15:0] cx, input logic [15:0] cy,
                           input logic [31:0] k1, input logic [31:0] k2,
                           input logic [31:0] p1, input logic [31:0] p2);
    write_reg(REG_FOCAL_X, {16'd0, fx});
    write_reg(REG_FOCAL_Y, {16'd0, fy});
    write_reg(REG_CENTER_X, {16'd0, cx});
    write_reg(REG_CENTER_Y, {16'd0, cy});
    write_reg(REG_K1, k1);
    write_reg(REG_K2, k2);
    write_reg(REG_P1, p1);
    write_reg(REG_P2, p2);
  endtask

  // Mostly gentle coefficients, sometimes full-scale ones or zero.
  function automatic logic [31:0] pick_coeff();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return 32'(signed'($urandom_range(1 << 25)) - (1 << 24));
      2:       return 32'(signed'($urandom_range(1 << 21)) - (1 << 20));
      default: return 32'd0;
    endcase
  endfunction

  function automatic logic [15:0] pick_focal();
    case ($urandom_range(3))
      0:       return 16'($urandom_range(255, 16));
      1:       return 16'($urandom_range(65535, 16));
      default: return 16'($urandom_range(20000, 4000));
    endcase
  endfunction

  initial begin
    logic [15:0] cx, cy;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    send_idle_pct = 29;
    stall_pct     = 86;
    rst_n         = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: corners of the pixel range and two mixed points.
    send_point(16'd0, 16'd0);
    send_point(16'hffff, 16'hffff);
    send_point(16'd0, 16'hffff);
    send_point(16'hffff, 16'd0);
    send_point(16'h5555, 16'haaaa);
    send_point(16'haaaa, 16'h5555);
    drain();

    // Strong negative k1: denominator goes non-positive away from the centre.
    load_lens(16'd16, 16'd16, 16'h8000, 16'h8000,
              32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
    send_point(16'h8000, 16'h8000);
    send_point(16'h8010, 16'h8010);
    send_point(16'h8100, 16'h7f00);
    send_point(16'd0, 16'hffff);
    send_point(16'hffff, 16'd0);
    drain();

    // Widest focal lengths, full-scale positive radial and negative tangential coefficients, centre at the top.
    load_lens(16'hffff, 16'hffff, 16'hffff, 16'hffff,
              32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000);
    send_point(16'hffff, 16'hffff);
    send_point(16'd0, 16'd0);
    send_point(16'hfff0, 16'hffff);
    send_point(16'h0001, 16'h8000);
    drain();

    // Plain pinhole: zero coefficients.
    load_lens(16'd8000, 16'd12000, 16'd5000, 16'd3000, '0, '0, '0, '0);
    send_point(16'd5000, 16'd3000);
    send_point(16'd5001, 16'd2999);
    send_point(16'hffff, 16'd0);
    drain();

    // Random lenses, eight phases of a hundred points each.
    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 3) begin
        send_idle_pct = 29;
        stall_pct     = 86;
      end else if (ph < 6) begin
        send_idle_pct = 86;
        stall_pct     = 29;
      end else begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
      cx = 16'($urandom);
      cy = 16'($urandom);
      load_lens(pick_focal(), pick_focal(), cx, cy,
                pick_coeff(), pick_coeff(), pick_coeff(), pick_coeff());
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(1))
          send_point(16'($urandom), 16'($urandom));
        else
          send_point(cx + 16'($urandom_range(2047)) - 16'd1024,
                     cy + 16'($urandom_range(2047)) - 16'd1024);
      end
      drain();
    end

    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
